[rtl/qgac_pkg.sv]
// qgac_pkg: widths, latencies, constants and helpers for the quaternion attitude core
// no dependencies; imported by qgac_sqrt, qgac_cordic and the top level
`default_nettype none

package qgac_pkg;

    localparam int DATA_W     = 16;
    localparam int IN_TDATA_W = 112;
    localparam int OUT_TDATA_W = 144;

    // integer square root
    localparam int SQ_IN_W   = 32;
    localparam int SQ_OUT_W  = SQ_IN_W / 2;
    localparam int SQ_REM_W  = SQ_OUT_W + 2;
    localparam int SQ_STEPS  = SQ_OUT_W;
    localparam int SQ_PER    = 4;
    localparam int SQ_STAGES = SQ_STEPS / SQ_PER;

    // cordic vectoring
    localparam int CW_IN      = 34;
    localparam int CW         = 44;
    localparam int NORM_BIT   = 40;
    localparam int SH_W       = 6;
    localparam int ANG_W      = 24;
    localparam int ROUND_SH   = 7;
    localparam int ANG_OUT_W  = ANG_W - ROUND_SH;
    localparam int IT_STEPS   = 20;
    localparam int IT_PER     = 2;
    localparam int IT_STAGES  = IT_STEPS / IT_PER;
    localparam int CORDIC_LAT = IT_STAGES + 4;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q20 = 24'sd1647099;
    localparam logic signed [ANG_W-1:0] ROUND_ADD   = 24'sd64;
    localparam logic signed [ANG_OUT_W-1:0] YAW_LIMIT  = 17'sd25736;
    localparam logic signed [ANG_OUT_W-1:0] TILT_LIMIT = 17'sd12868;
    localparam logic signed [CW_IN-1:0] YAW_BIAS = 34'sd134217728;

    // front end: products, gravity, squares, sums
    localparam int FRONT_LAT = 4;
    localparam int YAW_DLY   = SQ_STAGES + 2;
    localparam int GL_DLY    = SQ_STAGES + CORDIC_LAT + 1;
    localparam int LAT       = FRONT_LAT + SQ_STAGES + CORDIC_LAT + 1;

    typedef struct packed {
        logic signed [DATA_W-1:0] gx;
        logic signed [DATA_W-1:0] gy;
        logic signed [DATA_W-1:0] gz;
        logic signed [DATA_W-1:0] lx;
        logic signed [DATA_W-1:0] ly;
        logic signed [DATA_W-1:0] lz;
    } t_grav_lin;

    function automatic logic [ANG_W-1:0] atan_q20(input logic [4:0] idx);
        logic [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 24'd823550;
            5'd1:    v = 24'd486170;
            5'd2:    v = 24'd256879;
            5'd3:    v = 24'd130396;
            5'd4:    v = 24'd65451;
            5'd5:    v = 24'd32757;
            5'd6:    v = 24'd16383;
            5'd7:    v = 24'd8192;
            5'd8:    v = 24'd4096;
            5'd9:    v = 24'd2048;
            5'd10:   v = 24'd1024;
            5'd11:   v = 24'd512;
            5'd12:   v = 24'd256;
            5'd13:   v = 24'd128;
            5'd14:   v = 24'd64;
            5'd15:   v = 24'd32;
            5'd16:   v = 24'd16;
            5'd17:   v = 24'd8;
            5'd18:   v = 24'd4;
            5'd19:   v = 24'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [35:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 36'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -36'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/qgac_sqrt.sv]
// qgac_sqrt: pipelined floor integer square root, several digits per stage
// depends on qgac_pkg
`default_nettype none

module qgac_sqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [qgac_pkg::SQ_IN_W-1:0] i_num,
    output logic [qgac_pkg::SQ_OUT_W-1:0]     o_root
);
    import qgac_pkg::*;

    logic [SQ_IN_W-1:0]  w_num  [SQ_STAGES+1];
    logic [SQ_REM_W-1:0] w_rem  [SQ_STAGES+1];
    logic [SQ_OUT_W-1:0] w_root [SQ_STAGES+1];

    assign w_num[0]  = i_num;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
        logic [SQ_IN_W-1:0]  n_num,  r_num;
        logic [SQ_REM_W-1:0] n_rem,  r_rem;
        logic [SQ_OUT_W-1:0] n_root, r_root;

        always_comb begin
            n_num  = w_num[s];
            n_rem  = w_rem[s];
            n_root = w_root[s];
            for (int j = 0; j < SQ_PER; j++) begin
                logic [SQ_REM_W+1:0] rt;
                logic [SQ_REM_W+1:0] trial;
                rt    = {n_rem, n_num[SQ_IN_W-1 -: 2]};
                trial = {2'b00, n_root, 2'b01};
                if (rt >= trial) begin
                    n_rem  = SQ_REM_W'(rt - trial);
                    n_root = {n_root[SQ_OUT_W-2:0], 1'b1};
                end else begin
                    n_rem  = SQ_REM_W'(rt);
                    n_root = {n_root[SQ_OUT_W-2:0], 1'b0};
                end
                n_num = {n_num[SQ_IN_W-3:0], 2'b00};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num  <= n_num;
                r_rem  <= n_rem;
                r_root <= n_root;
            end
        end

        assign w_num[s+1]  = r_num;
        assign w_rem[s+1]  = r_rem;
        assign w_root[s+1] = r_root;
    end

    assign o_root = w_root[SQ_STAGES];

endmodule

`default_nettype wire

[rtl/qgac_cordic.sv]
// qgac_cordic: pipelined atan2 by vectoring cordic, pre-rotation, normalisation, rounding
// depends on qgac_pkg
`default_nettype none

module qgac_cordic (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic signed [qgac_pkg::CW_IN-1:0]    i_y,
    input  wire logic signed [qgac_pkg::CW_IN-1:0]    i_x,
    output logic signed [qgac_pkg::ANG_OUT_W-1:0]     o_angle
);
    import qgac_pkg::*;

    // pre-rotation into the right half plane
    logic signed [CW_IN-1:0] n_ax, n_ay, r_ax, r_ay;
    logic signed [ANG_W-1:0] n_aacc, r_aacc;
    logic [CW_IN-1:0]        n_am, r_am;
    logic [CW_IN-1:0]        w_aymag;

    always_comb begin
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_ax   = i_y;
                n_ay   = -i_x;
                n_aacc = HALF_PI_Q20;
            end else begin
                n_ax   = -i_y;
                n_ay   = i_x;
                n_aacc = -HALF_PI_Q20;
            end
        end else begin
            n_ax   = i_x;
            n_ay   = i_y;
            n_aacc = '0;
        end
        w_aymag = n_ay[CW_IN-1] ? CW_IN'(-n_ay) : CW_IN'(n_ay);
        n_am    = (CW_IN'(n_ax) > w_aymag) ? CW_IN'(n_ax) : w_aymag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax   <= n_ax;
            r_ay   <= n_ay;
            r_aacc <= n_aacc;
            r_am   <= n_am;
        end
    end

    // leading one search for the normalising shift
    logic signed [CW_IN-1:0] r_bx, r_by;
    logic signed [ANG_W-1:0] r_bacc;
    logic [SH_W-1:0]         n_bk, r_bk;
    logic                    n_bzero, r_bzero;
    logic [SH_W:0]           w_len;

    always_comb begin
        w_len = '0;
        for (int b = 0; b < CW_IN; b++) begin
            if (r_am[b]) begin
                w_len = (SH_W+1)'(b + 1);
            end
        end
        n_bk    = SH_W'((SH_W+1)'(NORM_BIT + 1) - w_len);
        n_bzero = (r_am == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bx    <= r_ax;
            r_by    <= r_ay;
            r_bacc  <= r_aacc;
            r_bk    <= n_bk;
            r_bzero <= n_bzero;
        end
    end

    // normalising shift, then the micro-rotations
    logic signed [CW-1:0]    r_x    [IT_STAGES+1];
    logic signed [CW-1:0]    r_y    [IT_STAGES+1];
    logic signed [ANG_W-1:0] r_acc  [IT_STAGES+1];
    logic                    r_zero [IT_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= CW'(r_bx) <<< r_bk;
            r_y[0]    <= CW'(r_by) <<< r_bk;
            r_acc[0]  <= r_bacc;
            r_zero[0] <= r_bzero;
        end
    end

    for (genvar s = 0; s < IT_STAGES; s++) begin : g_iter
        logic signed [CW-1:0]    n_x, n_y;
        logic signed [ANG_W-1:0] n_acc;

        always_comb begin
            n_x   = r_x[s];
            n_y   = r_y[s];
            n_acc = r_acc[s];
            for (int j = 0; j < IT_PER; j++) begin
                logic signed [CW-1:0] dx;
                logic signed [CW-1:0] dy;
                dx = n_x >>> (s * IT_PER + j);
                dy = n_y >>> (s * IT_PER + j);
                if (!n_y[CW-1]) begin
                    n_x   = n_x + dy;
                    n_y   = n_y - dx;
                    n_acc = n_acc + $signed(atan_q20(5'(s * IT_PER + j)));
                end else begin
                    n_x   = n_x - dy;
                    n_y   = n_y + dx;
                    n_acc = n_acc - $signed(atan_q20(5'(s * IT_PER + j)));
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s+1]    <= n_x;
                r_y[s+1]    <= n_y;
                r_acc[s+1]  <= n_acc;
                r_zero[s+1] <= r_zero[s];
            end
        end
    end

    // round to q13, zero vector gives zero
    logic signed [ANG_W-1:0]     w_rnd;
    logic signed [ANG_OUT_W-1:0] r_ang;

    assign w_rnd = r_acc[IT_STAGES] + ROUND_ADD;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= r_zero[IT_STAGES] ? '0 : w_rnd[ANG_W-1:ROUND_SH];
        end
    end

    assign o_angle = r_ang;

endmodule

`default_nettype wire

[rtl/quaternion_to_gravity_and_attitude_core.sv]
// quaternion_to_gravity_and_attitude_core: gravity vector, yaw/pitch/roll, linear acceleration
// depends on qgac_pkg, qgac_sqrt, qgac_cordic
//
//  channel  | dir | tdata fields (lsb first)
//  ---------+-----+-------------------------------------------------------------
//  s_axis   | in  | quat_w quat_x quat_y quat_z raw_accel_x raw_accel_y raw_accel_z
//  m_axis   | out | gravity_x/y/z yaw pitch roll linear_accel_x/y/z, 2 pad bits
//
// one item per cycle unless a held output stalls the pipeline; the path runs through the four-stage square root
// and the fourteen-stage cordic that follows it
// i_rst_n clears only the valid bits; data registers are not reset
// a held output stalls the whole pipeline and s_axis_tready drops; it is high
// whenever the output register is empty or being taken
`default_nettype none

module quaternion_to_gravity_and_attitude_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, raw_accel_x, raw_accel_y, raw_accel_z
    input  wire logic [qgac_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // gravity_x, gravity_y, gravity_z, yaw, pitch, roll,
    // linear_accel_x, linear_accel_y, linear_accel_z, zero pad
    output logic [qgac_pkg::OUT_TDATA_W-1:0]          m_axis_tdata
);
    import qgac_pkg::*;

    logic             w_en;
    logic [LAT-1:0]   r_vld;

    assign w_en          = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // stage 1: products
    logic signed [DATA_W-1:0] w_qw, w_qx, w_qy, w_qz;
    logic signed [DATA_W-1:0] r1_ax, r1_ay, r1_az, r2_ax, r2_ay, r2_az;
    logic signed [31:0] r_ww, r_xx, r_yy, r_zz, r_xz, r_wy, r_wx, r_yz, r_xy, r_wz;

    assign w_qw = s_axis_tdata[15:0];
    assign w_qx = s_axis_tdata[31:16];
    assign w_qy = s_axis_tdata[47:32];
    assign w_qz = s_axis_tdata[63:48];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ww  <= w_qw * w_qw;
            r_xx  <= w_qx * w_qx;
            r_yy  <= w_qy * w_qy;
            r_zz  <= w_qz * w_qz;
            r_xz  <= w_qx * w_qz;
            r_wy  <= w_qw * w_qy;
            r_wx  <= w_qw * w_qx;
            r_yz  <= w_qy * w_qz;
            r_xy  <= w_qx * w_qy;
            r_wz  <= w_qw * w_qz;
            r1_ax <= s_axis_tdata[79:64];
            r1_ay <= s_axis_tdata[95:80];
            r1_az <= s_axis_tdata[111:96];
        end
    end

    // stage 2: gravity and yaw operands
    logic signed [35:0] w_sx, w_sy, w_sz;
    logic signed [DATA_W-1:0] r2_gx, r2_gy, r2_gz;
    logic signed [CW_IN-1:0]  r2_yy, r2_yx;

    assign w_sx = (36'(r_xz) - 36'(r_wy) + 36'sd4096) >>> 13;
    assign w_sy = (36'(r_wx) + 36'(r_yz) + 36'sd4096) >>> 13;
    assign w_sz = (36'(r_ww) - 36'(r_xx) - 36'(r_yy) + 36'(r_zz) + 36'sd8192) >>> 14;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_gx <= sat16(w_sx);
            r2_gy <= sat16(w_sy);
            r2_gz <= sat16(w_sz);
            r2_yy <= CW_IN'(r_xy) - CW_IN'(r_wz);
            r2_yx <= CW_IN'(r_ww) + CW_IN'(r_xx) - YAW_BIAS;
            r2_ax <= r1_ax;
            r2_ay <= r1_ay;
            r2_az <= r1_az;
        end
    end

    // stage 3: squares and linear acceleration
    logic signed [35:0] w_dx, w_dy, w_dz;
    logic [SQ_IN_W-1:0] r_gx2, r_gy2, r_gz2;
    t_grav_lin          r3_gl;
    logic signed [31:0] w_gx2, w_gy2, w_gz2;

    assign w_dx = 36'(r2_ax) * 36'sd2 - 36'(r2_gx);
    assign w_dy = 36'(r2_ay) * 36'sd2 - 36'(r2_gy);
    assign w_dz = 36'(r2_az) * 36'sd2 - 36'(r2_gz);
    assign w_gx2 = r2_gx * r2_gx;
    assign w_gy2 = r2_gy * r2_gy;
    assign w_gz2 = r2_gz * r2_gz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gx2    <= SQ_IN_W'(w_gx2);
            r_gy2    <= SQ_IN_W'(w_gy2);
            r_gz2    <= SQ_IN_W'(w_gz2);
            r3_gl.gx <= r2_gx;
            r3_gl.gy <= r2_gy;
            r3_gl.gz <= r2_gz;
            r3_gl.lx <= sat16($signed(w_dx + 36'(w_dx[35])) >>> 1);
            r3_gl.ly <= sat16($signed(w_dy + 36'(w_dy[35])) >>> 1);
            r3_gl.lz <= sat16($signed(w_dz + 36'(w_dz[35])) >>> 1);
        end
    end

    // stage 4: sums under the square roots
    logic [SQ_IN_W-1:0] r_sum_p, r_sum_r;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum_p <= r_gy2 + r_gz2;
            r_sum_r <= r_gx2 + r_gz2;
        end
    end

    // delay lines
    t_grav_lin               r_gl  [GL_DLY];
    logic signed [CW_IN-1:0] r_ydy [YAW_DLY];
    logic signed [CW_IN-1:0] r_ydx [YAW_DLY];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gl[0]  <= r3_gl;
            r_ydy[0] <= r2_yy;
            r_ydx[0] <= r2_yx;
            for (int k = 1; k < GL_DLY; k++) begin
                r_gl[k] <= r_gl[k-1];
            end
            for (int k = 1; k < YAW_DLY; k++) begin
                r_ydy[k] <= r_ydy[k-1];
                r_ydx[k] <= r_ydx[k-1];
            end
        end
    end

    // square roots
    logic [SQ_OUT_W-1:0] w_sq_p, w_sq_r;

    qgac_sqrt u_sqrt_p (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_sum_p),
        .o_root (w_sq_p)
    );

    qgac_sqrt u_sqrt_r (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_sum_r),
        .o_root (w_sq_r)
    );

    // angles
    logic signed [ANG_OUT_W-1:0] w_yaw, w_pitch, w_roll;
    t_grav_lin                   w_gl_at;

    assign w_gl_at = r_gl[SQ_STAGES];

    qgac_cordic u_cordic_yaw (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (r_ydy[YAW_DLY-1]),
        .i_x     (r_ydx[YAW_DLY-1]),
        .o_angle (w_yaw)
    );

    qgac_cordic u_cordic_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (CW_IN'(w_gl_at.gx)),
        .i_x     ($signed({{(CW_IN-SQ_OUT_W){1'b0}}, w_sq_p})),
        .o_angle (w_pitch)
    );

    qgac_cordic u_cordic_roll (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (CW_IN'(w_gl_at.gy)),
        .i_x     ($signed({{(CW_IN-SQ_OUT_W){1'b0}}, w_sq_r})),
        .o_angle (w_roll)
    );

    // output register with angle clamps
    t_grav_lin                w_gl_out;
    logic signed [ANG_OUT_W-1:0] w_yaw_c, w_pitch_c, w_roll_c;
    logic [OUT_TDATA_W-1:0]   r_tdata;

    assign w_gl_out  = r_gl[GL_DLY-1];
    assign w_yaw_c   = (w_yaw > YAW_LIMIT) ? YAW_LIMIT :
                       ((w_yaw < -YAW_LIMIT) ? -YAW_LIMIT : w_yaw);
    assign w_pitch_c = (w_pitch > TILT_LIMIT) ? TILT_LIMIT :
                       ((w_pitch < -TILT_LIMIT) ? -TILT_LIMIT : w_pitch);
    assign w_roll_c  = (w_roll > TILT_LIMIT) ? TILT_LIMIT :
                       ((w_roll < -TILT_LIMIT) ? -TILT_LIMIT : w_roll);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tdata <= {2'b00, w_gl_out.lz, w_gl_out.ly, w_gl_out.lx,
                        w_roll_c[14:0], w_pitch_c[14:0], w_yaw_c[15:0],
                        w_gl_out.gz, w_gl_out.gy, w_gl_out.gx};
        end
    end

    assign m_axis_tdata = r_tdata;

endmodule

`default_nettype wire

[tb/quaternion_to_gravity_and_attitude_core_tb.sv]
// testbench for quaternion_to_gravity_and_attitude_core: random and directed stream items,
// a bit-exact gravity/angle/linear-acceleration predictor and a scoreboard
// depends on qgac_pkg and the core rtl
`default_nettype none

module quaternion_to_gravity_and_attitude_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qgac_pkg::*;

    localparam int WDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = LAT + 10;
    localparam int HOLD_CYCLES = 120;
    localparam int HOLD_AT = 150;
    localparam int PAUSE_AT = 500;
    localparam longint NORM_LEVEL = 64'sd1 <<< 40;
    localparam longint HALF_PI = 64'sd1647099;
    localparam longint ATAN_STEP[20] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct {
        logic signed [15:0] qw, qx, qy, qz, ax, ay, az;
    } t_sample;

    typedef struct {
        logic signed [15:0] gx, gy, gz, yaw;
        logic signed [14:0] pitch, roll;
        logic signed [15:0] lx, ly, lz;
    } t_attitude;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;    // quat_w x y z, raw_accel_x y z
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;      // gravity x y z, yaw, pitch, roll, lin x y z, pad

    t_sample samples_pending[$];
    t_attitude attitude_expected[$];
    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit pause_done = 1'b0;
    bit stim_done = 1'b0;

    quaternion_to_gravity_and_attitude_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint isqrt(longint n);
        longint res, bitv;
        res = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > n) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >>> 1) + bitv;
            end else begin
                res = res >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint acc, t, m, dx, dy;
        acc = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; acc = HALF_PI;
            end else begin
                t = x; x = -y; y = t; acc = -HALF_PI;
            end
        end
        m = mag(x) > mag(y) ? mag(x) : mag(y);
        if (m == 0) return 0;
        while (m < NORM_LEVEL) begin
            x = x * 2; y = y * 2; m = m * 2;
        end
        for (int i = 0; i < 20; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y >= 0) begin
                x = x + dy; y = y - dx; acc = acc + ATAN_STEP[i];
            end else begin
                x = x - dy; y = y + dx; acc = acc - ATAN_STEP[i];
            end
        end
        return (acc + 64) >>> 7;
    endfunction

    function automatic t_attitude predict_attitude(t_sample s);
        t_attitude r;
        longint w, x, y, z, gx, gy, gz, rt;
        w = s.qw; x = s.qx; y = s.qy; z = s.qz;
        gx = clip((x * z - w * y + 4096) >>> 13, -32768, 32767);
        gy = clip((w * x + y * z + 4096) >>> 13, -32768, 32767);
        gz = clip((w * w - x * x - y * y + z * z + 8192) >>> 14, -32768, 32767);
        r.gx = gx; r.gy = gy; r.gz = gz;
        r.yaw = clip(vector_angle(x * y - w * z, w * w + x * x - (64'sd1 <<< 27)),
                     -25736, 25736);
        rt = isqrt(gy * gy + gz * gz);
        r.pitch = clip(vector_angle(gx, rt), -12868, 12868);
        rt = isqrt(gx * gx + gz * gz);
        r.roll = clip(vector_angle(gy, rt), -12868, 12868);
        r.lx = clip((2 * longint'(s.ax) - gx) / 2, -32768, 32767);
        r.ly = clip((2 * longint'(s.ay) - gy) / 2, -32768, 32767);
        r.lz = clip((2 * longint'(s.az) - gz) / 2, -32768, 32767);
        return r;
    endfunction

    function automatic logic signed [15:0] rnd16();
        return 16'($urandom);
    endfunction

    task automatic add_sample(int w, int x, int y, int z, int ax, int ay, int az);
        t_sample s;
        s.qw = w; s.qx = x; s.qy = y; s.qz = z;
        s.ax = ax; s.ay = ay; s.az = az;
        samples_pending.push_back(s);
    endtask

    task automatic add_unit_sample(bit exact);
        real c[4], n, sc;
        int v[4];
        int gz_cnt;
        for (int k = 0; k < 4; k++) c[k] = real'($urandom_range(0, 32768)) - 16384.0;
        n = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
        if (n < 1.0) begin
            c[0] = 1.0; n = 1.0;
        end
        sc = exact ? 16384.0 : 16384.0 * (0.5 + real'($urandom_range(0, 1500)) / 1000.0);
        for (int k = 0; k < 4; k++) v[k] = int'(clip(longint'($rtoi(c[k] / n * sc)),
                                                   -32768, 32767));
        gz_cnt = $urandom_range(0, 16000);
        add_sample(v[0], v[1], v[2], v[3], int'(rnd16()) / 4, int'(rnd16()) / 4,
                   gz_cnt - 8000 + int'(rnd16()) / 8);
    endtask

    initial begin
        // identity, zero, extremes, tilt at plus and minus a quarter turn, yaw wrap side
        add_sample(16384, 0, 0, 0, 0, 0, 8192);
        add_sample(0, 0, 0, 0, 0, 0, 0);
        add_sample(32767, 32767, 32767, 32767, 32767, 32767, 32767);
        add_sample(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
        add_sample(32767, -32768, 32767, -32768, -32768, 32767, -32768);
        add_sample(-32768, 32767, -32768, 32767, 32767, -32768, 32767);
        add_sample(11585, 0, -11585, 0, 8192, 0, 0);
        add_sample(11585, 0, 11585, 0, -8192, 0, 0);
        add_sample(11585, 11585, 0, 0, 0, 8192, 0);
        add_sample(11585, -11585, 0, 0, 0, -8192, 0);
        add_sample(0, 16384, 0, 0, 0, 0, -8192);
        add_sample(0, 0, 0, 16384, 100, -100, 8192);
        add_sample(11585, 0, 0, 11585, 0, 0, 8192);
        add_sample(11585, 0, 0, -11585, 0, 0, 8192);
        add_sample(0, 11585, 11585, 0, 0, 0, 0);
        add_sample(0, 11585, -11585, 0, 0, 0, 0);
        add_sample(0, 0, 16384, 0, 32767, 32767, 32767);
        add_sample(8192, 8192, 8192, 8192, -32768, -32768, -32768);
        add_sample(16384, 0, 0, 0, 32767, -32768, -32768);
        add_sample(-16384, 0, 0, 0, -32768, 32767, 32767);
        for (int i = 0; i < 930; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_unit_sample(1'b1);
                4, 5, 6:    add_unit_sample(1'b0);
                default:    add_sample(rnd16(), rnd16(), rnd16(), rnd16(),
                                       rnd16(), rnd16(), rnd16());
            endcase
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (samples_pending.size() == 0 && !s_axis_tvalid && attitude_expected.size() == 0);
        stim_done = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d items sent, %0d results checked: extremes, quarter-turn tilts, unit and",
                 n_sent, n_checked);
        $display("scaled quaternions, full-range noise, under random and held back-pressure");
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // sender
    always @(posedge i_clk) begin
        int idle_pct;
        t_sample s;
        idle_pct = n_sent < 320 ? 21 : (n_sent < 640 ? 61 : 0);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) n_sent <= n_sent + 1;
            if (n_sent + s_axis_tvalid == PAUSE_AT && !pause_done) begin
                s_axis_tvalid <= 1'b0;
                if (!s_axis_tvalid && attitude_expected.size() == 0) pause_done <= 1'b1;
            end else if (samples_pending.size() == 0 || $urandom_range(0, 99) < idle_pct) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                s = samples_pending.pop_front();
                s_axis_tdata <= {s.az, s.ay, s.ax, s.qz, s.qy, s.qx, s.qw};
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // receiver and scoreboard
    always @(posedge i_clk) begin
        int idle_pct;
        t_sample s;
        t_attitude got, exp_r;
        idle_pct = n_sent < 320 ? 61 : (n_sent < 640 ? 21 : 0);
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            s.qw = s_axis_tdata[15:0];   s.qx = s_axis_tdata[31:16];
            s.qy = s_axis_tdata[47:32];  s.qz = s_axis_tdata[63:48];
            s.ax = s_axis_tdata[79:64];  s.ay = s_axis_tdata[95:80];
            s.az = s_axis_tdata[111:96];
            attitude_expected.push_back(predict_attitude(s));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.gx = m_axis_tdata[15:0];     got.gy = m_axis_tdata[31:16];
            got.gz = m_axis_tdata[47:32];    got.yaw = m_axis_tdata[63:48];
            got.pitch = m_axis_tdata[78:64]; got.roll = m_axis_tdata[93:79];
            got.lx = m_axis_tdata[109:94];   got.ly = m_axis_tdata[125:110];
            got.lz = m_axis_tdata[141:126];
            if (attitude_expected.size() == 0) begin
                $error("unexpected result item");
                n_errors++;
            end else begin
                exp_r = attitude_expected.pop_front();
                n_checked++;
                if (got.gx !== exp_r.gx) begin
                    $error("gravity_x exp %0d got %0d", exp_r.gx, got.gx); n_errors++;
                end
                if (got.gy !== exp_r.gy) begin
                    $error("gravity_y exp %0d got %0d", exp_r.gy, got.gy); n_errors++;
                end
                if (got.gz !== exp_r.gz) begin
                    $error("gravity_z exp %0d got %0d", exp_r.gz, got.gz); n_errors++;
                end
                if (got.yaw !== exp_r.yaw) begin
                    $error("yaw exp %0d got %0d", exp_r.yaw, got.yaw); n_errors++;
                end
                if (got.pitch !== exp_r.pitch) begin
                    $error("pitch exp %0d got %0d", exp_r.pitch, got.pitch); n_errors++;
                end
                if (got.roll !== exp_r.roll) begin
                    $error("roll exp %0d got %0d", exp_r.roll, got.roll); n_errors++;
                end
                if (got.lx !== exp_r.lx) begin
                    $error("linear_accel_x exp %0d got %0d", exp_r.lx, got.lx); n_errors++;
                end
                if (got.ly !== exp_r.ly) begin
                    $error("linear_accel_y exp %0d got %0d", exp_r.ly, got.ly); n_errors++;
                end
                if (got.lz !== exp_r.lz) begin
                    $error("linear_accel_z exp %0d got %0d", exp_r.lz, got.lz); n_errors++;
                end
            end
        end
        if (!hold_done && n_sent >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= $urandom_range(0, 99) >= idle_pct;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || stim_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

`default_nettype wire
